>>> rtl/rlf_pkg.sv
// ----------------------------------------------------------------------------
// rlf_pkg: shared types and constants for the ranging line-follow controller
// Item layouts, op and register codes, and the seven-segment digit encoder.
// ----------------------------------------------------------------------------
package rlf_pkg;

	// Field widths fixed by the item layout
	localparam int TIMER_FIELD_W   = 16;
	localparam int TIMER_WIDTH_DEF = 16;
	localparam int SPEED_W         = 10;
	localparam int SEG_W           = 8;
	localparam int BRAKE_DIST_W    = 9;
	localparam int TICK_DIV_W      = 8;
	localparam int CFG_DATA_W      = 9;

	// Scaled distance carried into the display pipeline: (w*100+74)/4
	localparam int SCALED_W = 19;

	// Event op codes
	localparam logic [1:0] OP_RISE = 2'd0;
	localparam logic [1:0] OP_FALL = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	// Configuration register indexes
	localparam logic CFG_BRAKE_DIST = 1'b0;
	localparam logic CFG_TICK_DIV   = 1'b1;

	// Segment code of the digit zero
	localparam logic [SEG_W-1:0] SEG_ZERO = 8'hFC;

	typedef struct packed {
		logic [1:0]               op;
		logic [TIMER_FIELD_W-1:0] timer_value;
		logic                     ir_left;
		logic                     ir_mid;
		logic                     ir_rt;
	} evt_item_t;

	typedef struct packed {
		logic               left_brake;
		logic [SPEED_W-1:0] left_speed;
		logic               right_brake;
		logic [SPEED_W-1:0] right_speed;
		logic [SEG_W-1:0]   tens_segments;
		logic [SEG_W-1:0]   units_segments;
		logic [SEG_W-1:0]   tenths_segments;
		logic [SEG_W-1:0]   hundredths_segments;
	} res_item_t;

	// Motor command decided at the update tick
	typedef struct packed {
		logic               brake;
		logic [SPEED_W-1:0] left_speed;
		logic [SPEED_W-1:0] right_speed;
	} drive_t;

	// Request into the display pipeline
	typedef struct packed {
		drive_t              drive;
		logic                sat;
		logic [SCALED_W-1:0] scaled;
	} disp_req_t;

	// Seven-segment code of one decimal digit
	function automatic logic [SEG_W-1:0] seg7(input logic [3:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 8'hFC;
			4'd1: s = 8'h60;
			4'd2: s = 8'hDB;
			4'd3: s = 8'hF3;
			4'd4: s = 8'h67;
			4'd5: s = 8'hB7;
			4'd6: s = 8'hBF;
			4'd7: s = 8'hE4;
			4'd8: s = 8'hFF;
			4'd9: s = 8'hF7;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

>>> rtl/rlf_disp.sv
// ----------------------------------------------------------------------------
// rlf_disp: distance display pipeline
// Turns the scaled pulse width into hundredths of an inch, splits it into
// four digits and encodes them; carries the motor command alongside.
// ----------------------------------------------------------------------------
module rlf_disp
	import rlf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  disp_req_t req,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res
);

	// x/37 = (x*RECIP_37)>>24, exact for x below 621378
	localparam logic [18:0] RECIP_37 = 19'd453439;
	// x/25 = (x*RECIP_25)>>16, exact for x below 4681
	localparam logic [11:0] RECIP_25 = 12'd2622;
	localparam logic [13:0] HUND_MAX = 14'd9999;

	// Tens and ones of a value below 100
	function automatic logic [7:0] split2(input logic [6:0] v);
		logic [3:0] tens;
		logic [6:0] ones;
		tens = 4'd0;
		for (int i = 1; i < 10; i++) begin
			if (v >= 7'(10 * i)) tens = tens + 4'd1;
		end
		ones = v - 7'(tens) * 7'd10;
		return {tens, ones[3:0]};
	endfunction

	logic        v_s2, v_s3, v_s4, v_s5;
	logic        rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_out;
	drive_t      drv_s2, drv_s3, drv_s4, drv_s5;
	logic        sat_s2;
	logic [18:0] scaled_s2;
	logic [13:0] hund_s3, hund_s4;
	logic [6:0]  whole_s4, whole_s5, frac_s5;

	logic [37:0] prod37;
	logic [13:0] hund_d;
	logic [23:0] prod25;
	logic [6:0]  whole_d, frac_d;
	logic [7:0]  whole_dig, frac_dig;
	res_item_t   res_d;

	// Stage readiness: a stage takes a new item when empty or draining
	assign rdy_out   = !res_valid || !res_stall;
	assign rdy_s5    = !v_s5 || rdy_out;
	assign rdy_s4    = !v_s4 || rdy_s5;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign req_ready = rdy_s2;

	// Divide by 37 (the factor 4 of 148 is already shifted out)
	assign prod37 = 38'(scaled_s2) * 38'(RECIP_37);
	assign hund_d = sat_s2 ? HUND_MAX : prod37[37:24];

	// Whole inches: hundredths / 100
	assign prod25  = 24'(hund_s3[13:2]) * 24'(RECIP_25);
	assign whole_d = prod25[22:16];

	// Fractional hundredths
	assign frac_d = 7'(hund_s4 - 14'(whole_s4) * 14'd100);

	// Digits and segment codes
	assign whole_dig = split2(whole_s5);
	assign frac_dig  = split2(frac_s5);

	always_comb begin
		res_d.left_brake          = drv_s5.brake;
		res_d.left_speed          = drv_s5.left_speed;
		res_d.right_brake         = drv_s5.brake;
		res_d.right_speed         = drv_s5.right_speed;
		res_d.tens_segments       = (whole_dig[7:4] != 4'd0) ? seg7(whole_dig[7:4]) : '0;
		res_d.units_segments      = seg7(whole_dig[3:0]);
		res_d.tenths_segments     = seg7(frac_dig[7:4]);
		res_d.hundredths_segments = seg7(frac_dig[3:0]);
	end

	// Advance valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (rdy_s2) v_s2 <= req_valid;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_out) res_valid <= v_s5;
		end
	end

	// Advance payloads
	always_ff @(posedge clk) begin
		if (rdy_s2 && req_valid) begin
			drv_s2    <= req.drive;
			sat_s2    <= req.sat;
			scaled_s2 <= req.scaled;
		end
		if (rdy_s3 && v_s2) begin
			drv_s3  <= drv_s2;
			hund_s3 <= hund_d;
		end
		if (rdy_s4 && v_s3) begin
			drv_s4   <= drv_s3;
			hund_s4  <= hund_s3;
			whole_s4 <= whole_d;
		end
		if (rdy_s5 && v_s4) begin
			drv_s5   <= drv_s4;
			whole_s5 <= whole_s4;
			frac_s5  <= frac_d;
		end
		if (rdy_out && v_s5) begin
			res <= res_d;
		end
	end

endmodule

>>> rtl/ranging_line_follow_controller.sv
// ----------------------------------------------------------------------------
// ranging_line_follow_controller: ultrasonic ranging line-follow controller
// Measures echo pulse widths, and on every tick_divide-th scheduler tick
// issues motor commands and a four-digit distance display.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// evt     | in        | evt_valid/evt_stall  | evt_item_t: op, timer, IR levels
// res     | out       | res_valid/res_stall  | res_item_t: motors, segments
// cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// One item per cycle sustained while the display pipeline takes update ticks.
// An update tick goes from the input register to the request register, then
// one multiply stage for the divide by 148, one for the divide by 100, the
// remainder stage, and the result register, where the digits are encoded.
// Edge items and non-update ticks retire at once and make no result. Reset
// clears valid flags and echo timing and loads the configuration defaults.
// res_stall backs up through the stage chain; empty stages keep filling, so
// items are still taken while a result waits.
// ----------------------------------------------------------------------------
module ranging_line_follow_controller
	import rlf_pkg::*;
#(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  evt_valid,
	output logic                  evt_stall,
	input  evt_item_t             evt,
	output logic                  res_valid,
	input  logic                  res_stall,
	output res_item_t             res,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int TW_EFF = (TIMER_WIDTH < TIMER_FIELD_W) ? TIMER_WIDTH : TIMER_FIELD_W;
	localparam logic [TIMER_FIELD_W-1:0] TMASK = TIMER_FIELD_W'((33'd1 << TW_EFF) - 33'd1);
	// Widths at or above this saturate the display at 99.99
	localparam logic [15:0] SAT_WIDTH = 16'd14800;

	localparam logic [SPEED_W-1:0] SPD_0   = 10'd0;
	localparam logic [SPEED_W-1:0] SPD_300 = 10'd300;
	localparam logic [SPEED_W-1:0] SPD_350 = 10'd350;
	localparam logic [SPEED_W-1:0] SPD_400 = 10'd400;
	localparam logic [SPEED_W-1:0] SPD_450 = 10'd450;
	localparam logic [SPEED_W-1:0] SPD_500 = 10'd500;
	localparam logic [SPEED_W-1:0] SPD_550 = 10'd550;

	// Line-following speeds from the sensor pattern {left, center, right}
	function automatic logic [2*SPEED_W-1:0] line_speeds(input logic [2:0] lcr);
		logic [2*SPEED_W-1:0] sp;
		case (lcr)
			3'b010:  sp = {SPD_500, SPD_500};
			3'b000:  sp = {SPD_300, SPD_350};
			3'b100:  sp = {SPD_0,   SPD_450};
			3'b001:  sp = {SPD_450, SPD_0};
			3'b110:  sp = {SPD_0,   SPD_450};
			3'b011:  sp = {SPD_400, SPD_0};
			default: sp = {SPD_500, SPD_550};
		endcase
		return sp;
	endfunction

	logic [BRAKE_DIST_W-1:0]  brake_dist_q;
	logic [TICK_DIV_W-1:0]    tick_div_q;
	logic [TICK_DIV_W-1:0]    tick_phase_q;
	logic [TIMER_FIELD_W-1:0] rise_time_q;
	logic [TIMER_FIELD_W-1:0] pulse_width_q;

	logic      v_s1;
	evt_item_t evt_s1;

	logic [TIMER_FIELD_W-1:0] now;
	logic [TICK_DIV_W-1:0]    phase_inc, phase_d;
	logic                     emit, move_s1, rdy_s1;
	logic [17:0]              brake_limit;
	logic [22:0]              scaled_full;
	logic [2*SPEED_W-1:0]     speeds;
	disp_req_t                req;
	logic                     req_ready;

	// Input register readiness
	assign rdy_s1    = !v_s1 || move_s1;
	assign evt_stall = !rdy_s1;

	// Decode the held item against the current state
	assign now       = evt_s1.timer_value & TMASK;
	assign phase_inc = tick_phase_q + 8'd1;

	always_comb begin
		emit    = 1'b0;
		phase_d = tick_phase_q;
		if (evt_s1.op == OP_TICK) begin
			if (phase_inc >= tick_div_q) begin
				emit    = 1'b1;
				phase_d = '0;
			end else begin
				phase_d = phase_inc;
			end
		end
	end

	// Non-update items retire at once; update ticks wait for the display pipe
	assign move_s1 = v_s1 && (!emit || req_ready);

	// Build the motor command and the scaled distance
	assign brake_limit = 18'({1'b0, brake_dist_q} + 10'd1) * 18'd148;
	assign speeds      = line_speeds({evt_s1.ir_left, evt_s1.ir_mid, evt_s1.ir_rt});
	assign scaled_full = 23'(pulse_width_q) * 23'd100 + 23'd74;

	always_comb begin
		req.drive.brake = {2'b00, pulse_width_q} < brake_limit;
		if (req.drive.brake) begin
			req.drive.left_speed  = SPD_0;
			req.drive.right_speed = SPD_0;
		end else begin
			req.drive.left_speed  = speeds[2*SPEED_W-1:SPEED_W];
			req.drive.right_speed = speeds[SPEED_W-1:0];
		end
		req.sat    = pulse_width_q >= SAT_WIDTH;
		req.scaled = scaled_full[SCALED_W+1:2];
	end

	// Input register and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			brake_dist_q <= 9'd4;
			tick_div_q   <= 8'd8;
		end else begin
			if (rdy_s1) v_s1 <= evt_valid;
			if (cfg_we) begin
				case (cfg_index)
					CFG_BRAKE_DIST: brake_dist_q <= cfg_data[BRAKE_DIST_W-1:0];
					CFG_TICK_DIV:   tick_div_q   <= cfg_data[TICK_DIV_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && evt_valid) evt_s1 <= evt;
	end

	// Update echo timing and tick phase as each item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_phase_q  <= '0;
			rise_time_q   <= '0;
			pulse_width_q <= '0;
		end else if (move_s1) begin
			case (evt_s1.op)
				OP_RISE: rise_time_q   <= now;
				OP_FALL: pulse_width_q <= (now - rise_time_q) & TMASK;
				OP_TICK: tick_phase_q  <= phase_d;
				default: ;
			endcase
		end
	end

	rlf_disp u_disp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (v_s1 && emit),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

>>> rtl/rlf_checker.sv
// ----------------------------------------------------------------------------
// rlf_checker: port-level checks for the ranging line-follow controller
// Watches the result channel for handshake and content rules.
// ----------------------------------------------------------------------------
module rlf_checker
	import rlf_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      res_valid,
	input logic      res_stall,
	input res_item_t res
);

	// Hold a stalled result item
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result item changed while stalled");

	// Brake stops both motors
	a_brake_speed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.left_brake |-> res.left_speed == '0 && res.right_speed == '0)
		else $error("braking with nonzero speed");

	// Both motors share one brake decision
	a_brake_pair: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.left_brake == res.right_brake)
		else $error("brake flags disagree");

	// A zero tens digit is blanked, never shown as zero
	a_tens_blank: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.tens_segments != SEG_ZERO)
		else $error("zero tens digit not blanked");

	// The units digit is always lit
	a_units_lit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.units_segments != '0)
		else $error("units digit blank");

endmodule

bind ranging_line_follow_controller rlf_checker u_rlf_checker (.*);
